@@ src/assert_macros.svh @@
// Assertion macros shared by the lexer modules; they expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds on every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Condition that implies another in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition that implies another in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/kwl_pkg.sv @@
// Shared types, codes, character classes and keyword tables of the keyword lexer.
`timescale 1ns / 1ps

package kwl_pkg;

  localparam int MAX_LEXEME_DEF = 255;
  localparam int FIFO_DEPTH     = 4;

  // result kinds
  localparam logic [1:0] RK_TOKEN = 2'd0;
  localparam logic [1:0] RK_ERROR = 2'd1;
  localparam logic [1:0] RK_END   = 2'd2;

  // token kinds
  localparam logic [4:0] TK_REL    = 5'd0;
  localparam logic [4:0] TK_RPAR   = 5'd1;
  localparam logic [4:0] TK_LPAR   = 5'd2;
  localparam logic [4:0] TK_ASSIGN = 5'd3;
  localparam logic [4:0] TK_OR     = 5'd4;
  localparam logic [4:0] TK_AND    = 5'd5;
  localparam logic [4:0] TK_ID     = 5'd6;
  localparam logic [4:0] TK_MUL    = 5'd7;
  localparam logic [4:0] TK_SUM    = 5'd8;
  localparam logic [4:0] TK_NEG    = 5'd9;
  localparam logic [4:0] TK_NUM    = 5'd10;
  localparam logic [4:0] TK_KW0    = 5'd11;
  localparam logic [4:0] TK_QUOTED = 5'd18;

  // characters
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] tok;
    logic [7:0] len;
    logic       last;
  } res_t;

  // results of one processed character, handed to the output queue
  typedef struct packed {
    logic [1:0] count;
    res_t       res1;
    res_t       res0;
  } push_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] off;
  } kw_hit_t;

  typedef struct packed {
    logic [2:0] k;
    logic [2:0] p;
  } kw_pos_t;

  // keyword trie: end else if integer while string print
  localparam int NUM_KW = 7;
  localparam logic [7:0] KW_CHAR [NUM_KW][8] = '{
    '{8'h65, 8'h6E, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h6E, 8'h74, 8'h65, 8'h67, 8'h65, 8'h72, 8'h00},
    '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00},
    '{8'h73, 8'h74, 8'h72, 8'h69, 8'h6E, 8'h67, 8'h00, 8'h00},
    '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd4, 3'd2, 3'd7, 3'd5, 3'd6, 3'd5};
  localparam logic [4:0] KW_OFF [NUM_KW] = '{5'd0, 5'd3, 5'd7, 5'd9, 5'd16, 5'd21, 5'd27};

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  // which keyword and how many characters a trie offset stands for
  function automatic kw_pos_t kw_decode(input logic [4:0] off);
    kw_pos_t r;
    r.k = 3'd0;
    for (int i = 1; i < NUM_KW; i++) begin
      if (off >= KW_OFF[i]) r.k = 3'(i);
    end
    r.p = 3'(off - KW_OFF[r.k] + 5'd1);
    return r;
  endfunction

  // next trie offset for character c; lowest keyword index wins
  function automatic kw_hit_t kw_follow(input kw_pos_t pos, input logic [7:0] c);
    kw_hit_t r;
    logic    match;
    r.hit = 1'b0;
    r.off = 5'd0;
    for (int k2 = NUM_KW - 1; k2 >= 0; k2--) begin
      match = KW_LEN[k2] > pos.p;
      for (int j = 0; j < 7; j++) begin
        if (j < int'(pos.p) && KW_CHAR[k2][j] != KW_CHAR[pos.k][j]) match = 1'b0;
      end
      if (match && KW_CHAR[k2][pos.p] == c) begin
        r.hit = 1'b1;
        r.off = 5'(KW_OFF[k2] + 5'(pos.p));
      end
    end
    return r;
  endfunction

  // trie offset for the first character of a keyword
  function automatic kw_hit_t kw_first(input logic [7:0] c);
    kw_hit_t r;
    r.hit = 1'b0;
    r.off = 5'd0;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (KW_CHAR[k][0] == c) begin
        r.hit = 1'b1;
        r.off = KW_OFF[k];
      end
    end
    return r;
  endfunction

endpackage

@@ src/kwl_core.sv @@
// Input register, lexer state and the one-character transition logic.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kwl_core import kwl_pkg::*; #(
  parameter int MAX_LEXEME = MAX_LEXEME_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_eof,
  input  logic       room,
  output push_t      push
);

  localparam int LEN_CAP = (MAX_LEXEME < 255) ? MAX_LEXEME : 255;
  localparam logic [7:0] LEN_CAP8 = 8'(LEN_CAP);

  localparam logic [5:0] S_START      = 6'd0;
  localparam logic [5:0] S_ID         = 6'd1;
  localparam logic [5:0] S_NUM        = 6'd2;
  localparam logic [5:0] S_STR        = 6'd3;
  localparam logic [5:0] S_STR_END    = 6'd4;
  localparam logic [5:0] S_SLASH      = 6'd5;
  localparam logic [5:0] S_MUL        = 6'd6;
  localparam logic [5:0] S_ASSIGN     = 6'd7;
  localparam logic [5:0] S_ASSIGN_END = 6'd8;
  localparam logic [5:0] S_OR         = 6'd9;
  localparam logic [5:0] S_OR_END     = 6'd10;
  localparam logic [5:0] S_AND        = 6'd11;
  localparam logic [5:0] S_AND_END    = 6'd12;
  localparam logic [5:0] S_LPAR       = 6'd13;
  localparam logic [5:0] S_RPAR       = 6'd14;
  localparam logic [5:0] S_SUM        = 6'd15;
  localparam logic [5:0] S_NEG        = 6'd16;
  localparam logic [5:0] S_REL        = 6'd17;
  localparam logic [5:0] S_REL_END    = 6'd18;
  localparam logic [5:0] S_LINE       = 6'd19;
  localparam logic [5:0] S_BLOCK      = 6'd20;
  localparam logic [5:0] S_BLOCK_STAR = 6'd21;
  localparam logic [5:0] S_KW         = 6'd24;
  localparam logic [5:0] S_KW_LIMIT   = 6'd56;

  localparam logic [1:0] ACT_CONSUMED = 2'd0;
  localparam logic [1:0] ACT_TOKEN    = 2'd1;
  localparam logic [1:0] ACT_ERROR    = 2'd2;
  localparam logic [1:0] ACT_RESTART  = 2'd3;

  logic       hold_valid, hold_valid_next;
  logic [7:0] hold_char;
  logic       hold_eof;
  logic [5:0] state, state_next;
  logic [7:0] kept, kept_next;
  logic       process;

  logic [1:0] act;
  logic [4:0] tok;
  logic       to_start;
  logic [7:0] kc_base;
  logic [1:0] n;
  res_t       res [2];
  kw_pos_t    pos;
  kw_hit_t    fol;
  kw_hit_t    first;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v < LEN_CAP8) ? v + 8'd1 : v;
  endfunction

  assign process  = hold_valid && room;
  assign in_ready = !hold_valid || process;

  always_comb begin
    hold_valid_next = hold_valid;
    if (in_valid && in_ready) hold_valid_next = 1'b1;
    else if (process) hold_valid_next = 1'b0;
  end

  assign pos   = kw_decode(5'(state - S_KW));
  assign fol   = kw_follow(pos, hold_char);
  assign first = kw_first(hold_char);

  always_comb begin
    state_next = state;
    kept_next  = kept;
    act        = ACT_CONSUMED;
    tok        = TK_REL;
    to_start   = 1'b0;
    kc_base    = 8'd0;
    n          = 2'd0;
    res[0]     = '0;
    res[1]     = '0;

    if (state == S_START) begin
      to_start = 1'b1;
      kc_base  = kept;
    end else begin
      case (state)
        S_ID: begin
          if (!hold_eof && is_word(hold_char)) kept_next = sat_inc(kept);
          else begin act = ACT_TOKEN; tok = TK_ID; end
        end
        S_NUM: begin
          if (!hold_eof && is_digit(hold_char)) kept_next = sat_inc(kept);
          else begin act = ACT_TOKEN; tok = TK_NUM; end
        end
        S_STR: begin
          if (hold_eof) act = ACT_ERROR;
          else if (hold_char == CH_QUOTE) state_next = S_STR_END;
          else if (hold_char != CH_NL) kept_next = sat_inc(kept);
        end
        S_STR_END: begin act = ACT_TOKEN; tok = TK_QUOTED; end
        S_SLASH: begin
          if (!hold_eof && hold_char == CH_STAR) begin
            state_next = S_BLOCK;
            kept_next  = sat_inc(kept);
          end else if (!hold_eof && hold_char == CH_SLASH) begin
            state_next = S_LINE;
            kept_next  = sat_inc(kept);
          end else begin
            act = ACT_TOKEN;
            tok = TK_MUL;
          end
        end
        S_MUL:        begin act = ACT_TOKEN; tok = TK_MUL; end
        S_SUM:        begin act = ACT_TOKEN; tok = TK_SUM; end
        S_LPAR:       begin act = ACT_TOKEN; tok = TK_LPAR; end
        S_RPAR:       begin act = ACT_TOKEN; tok = TK_RPAR; end
        S_REL_END:    begin act = ACT_TOKEN; tok = TK_REL; end
        S_ASSIGN_END: begin act = ACT_TOKEN; tok = TK_ASSIGN; end
        S_OR_END:     begin act = ACT_TOKEN; tok = TK_OR; end
        S_AND_END:    begin act = ACT_TOKEN; tok = TK_AND; end
        S_REL, S_NEG: begin
          if (!hold_eof && hold_char == CH_EQ) begin
            state_next = S_REL_END;
            kept_next  = sat_inc(kept);
          end else begin
            act = ACT_TOKEN;
            tok = (state == S_REL) ? TK_REL : TK_NEG;
          end
        end
        S_ASSIGN: begin
          if (!hold_eof && hold_char == CH_EQ) begin
            state_next = S_ASSIGN_END;
            kept_next  = sat_inc(kept);
          end else act = ACT_ERROR;
        end
        S_OR: begin
          if (!hold_eof && hold_char == CH_BAR) begin
            state_next = S_OR_END;
            kept_next  = sat_inc(kept);
          end else act = ACT_ERROR;
        end
        S_AND: begin
          if (!hold_eof && hold_char == CH_AMP) begin
            state_next = S_AND_END;
            kept_next  = sat_inc(kept);
          end else act = ACT_ERROR;
        end
        S_LINE: begin
          if (hold_eof) act = ACT_RESTART;
          else if (hold_char == CH_NL) begin
            state_next = S_START;
            kept_next  = 8'd0;
          end else kept_next = sat_inc(kept);
        end
        S_BLOCK: begin
          if (hold_eof) act = ACT_ERROR;
          else if (hold_char == CH_STAR) begin
            state_next = S_BLOCK_STAR;
            kept_next  = sat_inc(kept);
          end
        end
        S_BLOCK_STAR: begin
          if (hold_eof) act = ACT_ERROR;
          else if (hold_char == CH_SLASH) begin
            state_next = S_START;
            kept_next  = 8'd0;
          end else if (hold_char != CH_STAR) state_next = S_BLOCK;
        end
        default: begin
          if (state >= S_KW && state < S_KW_LIMIT) begin
            if (!hold_eof && fol.hit) begin
              state_next = S_KW + {1'b0, fol.off};
              kept_next  = sat_inc(kept);
            end else if (!hold_eof && is_word(hold_char)) begin
              state_next = S_ID;
              kept_next  = sat_inc(kept);
            end else begin
              act = ACT_TOKEN;
              tok = (pos.p == KW_LEN[pos.k]) ? 5'(TK_KW0 + 5'(pos.k)) : TK_ID;
            end
          end else act = ACT_RESTART;
        end
      endcase

      case (act)
        ACT_TOKEN: begin
          res[0]   = '{kind: RK_TOKEN, tok: tok, len: kept, last: 1'b0};
          n        = 2'd1;
          to_start = 1'b1;
        end
        ACT_ERROR: begin
          res[0]     = '{kind: RK_ERROR, tok: TK_REL, len: 8'd0, last: 1'b0};
          n          = 2'd1;
          state_next = S_START;
          kept_next  = 8'd0;
          if (hold_eof) begin
            res[1] = '{kind: RK_END, tok: TK_REL, len: 8'd0, last: 1'b0};
            n      = 2'd2;
          end
        end
        ACT_RESTART: to_start = 1'b1;
        default: ;
      endcase
    end

    // re-examine the character from the start state
    if (to_start) begin
      state_next = S_START;
      kept_next  = kc_base;
      if (hold_eof) begin
        res[n[0]] = '{kind: RK_END, tok: TK_REL, len: 8'd0, last: 1'b0};
        n         = n + 2'd1;
        kept_next = 8'd0;
      end else if (first.hit) begin
        state_next = S_KW + {1'b0, first.off};
        kept_next  = sat_inc(kc_base);
      end else begin
        case (hold_char)
          CH_QUOTE:            state_next = S_STR;
          CH_STAR:             begin state_next = S_MUL;     kept_next = sat_inc(kc_base); end
          CH_SLASH:            begin state_next = S_SLASH;   kept_next = sat_inc(kc_base); end
          CH_COLON:            begin state_next = S_ASSIGN;  kept_next = sat_inc(kc_base); end
          CH_PLUS, CH_MINUS:   begin state_next = S_SUM;     kept_next = sat_inc(kc_base); end
          CH_BANG:             begin state_next = S_NEG;     kept_next = sat_inc(kc_base); end
          CH_BAR:              begin state_next = S_OR;      kept_next = sat_inc(kc_base); end
          CH_AMP:              begin state_next = S_AND;     kept_next = sat_inc(kc_base); end
          CH_LPAREN:           begin state_next = S_LPAR;    kept_next = sat_inc(kc_base); end
          CH_RPAREN:           begin state_next = S_RPAR;    kept_next = sat_inc(kc_base); end
          CH_LT, CH_GT:        begin state_next = S_REL;     kept_next = sat_inc(kc_base); end
          CH_EQ:               begin state_next = S_REL_END; kept_next = sat_inc(kc_base); end
          default: begin
            if (is_alpha(hold_char)) begin
              state_next = S_ID;
              kept_next  = sat_inc(kc_base);
            end else if (is_digit(hold_char)) begin
              state_next = S_NUM;
              kept_next  = sat_inc(kc_base);
            end else if (!is_space(hold_char)) begin
              // bad character: drop it
              res[n[0]] = '{kind: RK_ERROR, tok: TK_REL, len: 8'd0, last: 1'b0};
              n         = n + 2'd1;
              kept_next = 8'd0;
            end
          end
        endcase
      end
    end

    if (n == 2'd1) res[0].last = 1'b1;
    if (n == 2'd2) res[1].last = 1'b1;
  end

  assign push.count = process ? n : 2'd0;
  assign push.res0  = res[0];
  assign push.res1  = res[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      state      <= S_START;
      kept       <= 8'd0;
    end else begin
      hold_valid <= hold_valid_next;
      if (process) begin
        state <= state_next;
        kept  <= kept_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_char <= in_char;
      hold_eof  <= in_eof;
    end
  end

  `ASSERT_IMPLIES(a_start_empty, state == S_START, kept == 8'd0, "start state with kept text")
  `ASSERT_NEXT(a_eof_resets, process && hold_eof, state == S_START && kept == 8'd0, "eof left state")
  `ASSERT_NEXT(a_hold_stalled, hold_valid && !room, hold_valid && hold_char == $past(hold_char), "held char lost")

endmodule

@@ src/kwl_out_fifo.sv @@
// Result queue: takes up to two results a cycle, delivers one per transaction.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kwl_out_fifo import kwl_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, wr_ptr_next;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count, count_next;
  logic          pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign out_res   = mem[rd_ptr];
  // space for the worst case of two results
  assign room      = count <= CW'(DEPTH - 2);

  assign wr_ptr_next = wr_ptr + PW'(push.count);
  assign count_next  = count + CW'(push.count) - CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) rd_ptr <= rd_ptr + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.res0;
    if (push.count == 2'd2) mem[wr_ptr + PW'(1)] <= push.res1;
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH), "result queue overfilled")
  `ASSERT_IMPLIES(a_push_fits, push.count != 2'd0, CW'(push.count) + count <= CW'(DEPTH), "push without space")
  `ASSERT_NEXT(a_count_track, !pop, count == $past(count) + CW'($past(push.count)), "count drift")

endmodule

@@ src/keyword_token_lexer.sv @@
// Top level of the keyword lexer: character stream in, token stream out.
//
//  channel  dir  tdata                               tuser            tlast
//  s_*      in   [7:0] char_code                     end_of_input     -
//  m_*      out  [4:0] token_kind, [12:5] lexeme_len  [1:0] result_kind last_result
//
// One character is accepted per cycle while s_tready is high; it waits in the input
// register until the queue has room, and its results are then written into the queue.
// A character with two results takes two transactions on the single output port, which
// bounds the sustained rate at one result per cycle, reached while m_tready is high.
// rst is synchronous: the lexer returns to the start state and the queue empties.
// s_tready drops only when the queue lacks room for two results and the input
// register is full; m_tready low simply holds the queue head.
`timescale 1ns / 1ps

module keyword_token_lexer import kwl_pkg::*; #(
  parameter int MAX_LEXEME = MAX_LEXEME_DEF,
  parameter int DEPTH      = FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tuser,   // [0] end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [4:0] token_kind, [12:5] lexeme_length, [15:13] zero
  output logic [1:0]  m_tuser,   // [1:0] result_kind
  output logic        m_tlast    // last_result
);

  push_t push;
  logic  room;
  res_t  head;

  kwl_core #(.MAX_LEXEME(MAX_LEXEME)) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_char  (s_tdata),
    .in_eof   (s_tuser),
    .room     (room),
    .push     (push)
  );

  kwl_out_fifo #(.DEPTH(DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (head)
  );

  assign m_tdata = {3'b000, head.len, head.tok};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

@@ tb/keyword_token_lexer_test.sv @@
// Self-checking testbench for keyword_token_lexer: character stream in, checked token stream out.
`timescale 1ns / 1ps

module keyword_token_lexer_test import kwl_pkg::*; ();

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } lex_char_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] tok;
    logic [7:0] len;
    logic       last;
  } lex_result_t;

  typedef enum logic [4:0] {
    LX_START, LX_ID, LX_NUM, LX_STR, LX_STR_END, LX_SLASH, LX_MUL, LX_ASSIGN,
    LX_ASSIGN_END, LX_OR, LX_OR_END, LX_AND, LX_AND_END, LX_LPAR, LX_RPAR, LX_SUM,
    LX_NEG, LX_REL, LX_REL_END, LX_LINE, LX_BLOCK, LX_BLOCK_STAR, LX_KW
  } lex_state_e;

  typedef enum int {LA_HELD, LA_TOKEN, LA_ERROR, LA_QUIET} lex_action_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  lex_char_t   pending[$];
  lex_result_t results_due[$];

  // predictor state
  lex_state_e lx_state = LX_START;
  logic [7:0] lx_kept = 8'h00;
  int         kw_idx = 0;
  int         kw_got = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int fails = 0;
  int chars_in = 0;
  int n_tokens = 0;
  int n_errors = 0;
  int n_ends = 0;

  keyword_token_lexer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic string kw_word(input int k);
    case (k)
      0: return "end";
      1: return "else";
      2: return "if";
      3: return "integer";
      4: return "while";
      5: return "string";
      6: return "print";
      default: return "";
    endcase
  endfunction

  function automatic bit ch_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic bit ch_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit ch_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit ch_word(input logic [7:0] c);
    return ch_letter(c) || ch_digit(c) || c == CH_UNDER;
  endfunction

  function automatic void keep_to(input lex_state_e nxt);
    if (lx_kept != 8'hFF) lx_kept = lx_kept + 8'd1;
    lx_state = nxt;
  endfunction

  function automatic void lexer_clear();
    lx_state = LX_START;
    lx_kept = 8'h00;
  endfunction

  // extend the keyword prefix; the lowest keyword sharing the prefix wins
  function automatic bit kw_advance(input logic [7:0] c);
    string cur;
    string cand;
    cur = kw_word(kw_idx);
    for (int k = 0; k < NUM_KW; k++) begin
      cand = kw_word(k);
      if (cand.len() > kw_got && cand.substr(0, kw_got - 1) == cur.substr(0, kw_got - 1)
          && cand.getc(kw_got) == c) begin
        kw_idx = k;
        kw_got = kw_got + 1;
        keep_to(LX_KW);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic lex_action_e lex_pending(input logic [7:0] c, input logic eoi,
                                              output logic [4:0] tok);
    bit ch;
    ch = !eoi;
    tok = TK_REL;
    case (lx_state)
      LX_ID: begin
        if (ch && ch_word(c)) begin
          keep_to(LX_ID);
          return LA_HELD;
        end
        tok = TK_ID;
        return LA_TOKEN;
      end
      LX_NUM: begin
        if (ch && ch_digit(c)) begin
          keep_to(LX_NUM);
          return LA_HELD;
        end
        tok = TK_NUM;
        return LA_TOKEN;
      end
      LX_STR: begin
        if (eoi) return LA_ERROR;
        // quotes are not kept, a newline is skipped
        if (c == CH_QUOTE) lx_state = LX_STR_END;
        else if (c != CH_NL) keep_to(LX_STR);
        return LA_HELD;
      end
      LX_STR_END: begin
        tok = TK_QUOTED;
        return LA_TOKEN;
      end
      LX_SLASH: begin
        if (ch && c == CH_STAR) begin
          keep_to(LX_BLOCK);
          return LA_HELD;
        end
        if (ch && c == CH_SLASH) begin
          keep_to(LX_LINE);
          return LA_HELD;
        end
        tok = TK_MUL;
        return LA_TOKEN;
      end
      LX_MUL: begin
        tok = TK_MUL;
        return LA_TOKEN;
      end
      LX_SUM: begin
        tok = TK_SUM;
        return LA_TOKEN;
      end
      LX_LPAR: begin
        tok = TK_LPAR;
        return LA_TOKEN;
      end
      LX_RPAR: begin
        tok = TK_RPAR;
        return LA_TOKEN;
      end
      LX_REL_END: begin
        tok = TK_REL;
        return LA_TOKEN;
      end
      LX_ASSIGN_END: begin
        tok = TK_ASSIGN;
        return LA_TOKEN;
      end
      LX_OR_END: begin
        tok = TK_OR;
        return LA_TOKEN;
      end
      LX_AND_END: begin
        tok = TK_AND;
        return LA_TOKEN;
      end
      LX_REL: begin
        if (ch && c == CH_EQ) begin
          keep_to(LX_REL_END);
          return LA_HELD;
        end
        tok = TK_REL;
        return LA_TOKEN;
      end
      LX_NEG: begin
        if (ch && c == CH_EQ) begin
          keep_to(LX_REL_END);
          return LA_HELD;
        end
        tok = TK_NEG;
        return LA_TOKEN;
      end
      LX_ASSIGN: begin
        if (ch && c == CH_EQ) begin
          keep_to(LX_ASSIGN_END);
          return LA_HELD;
        end
        return LA_ERROR;
      end
      LX_OR: begin
        if (ch && c == CH_BAR) begin
          keep_to(LX_OR_END);
          return LA_HELD;
        end
        return LA_ERROR;
      end
      LX_AND: begin
        if (ch && c == CH_AMP) begin
          keep_to(LX_AND_END);
          return LA_HELD;
        end
        return LA_ERROR;
      end
      LX_LINE: begin
        if (eoi) return LA_QUIET;
        if (c == CH_NL) lexer_clear();
        else keep_to(LX_LINE);
        return LA_HELD;
      end
      LX_BLOCK: begin
        if (eoi) return LA_ERROR;
        if (c == CH_STAR) keep_to(LX_BLOCK_STAR);
        return LA_HELD;
      end
      LX_BLOCK_STAR: begin
        if (eoi) return LA_ERROR;
        if (c == CH_SLASH) lexer_clear();
        else if (c != CH_STAR) lx_state = LX_BLOCK;
        return LA_HELD;
      end
      LX_KW: begin
        if (ch && kw_advance(c)) return LA_HELD;
        if (ch && ch_word(c)) begin
          keep_to(LX_ID);
          return LA_HELD;
        end
        tok = (kw_got == kw_word(kw_idx).len()) ? TK_KW0 + 5'(kw_idx) : TK_ID;
        return LA_TOKEN;
      end
      default: return LA_QUIET;
    endcase
  endfunction

  // start state with a real character; false on a bad character
  function automatic bit lex_start(input logic [7:0] c);
    lex_state_e nxt;
    nxt = LX_START;
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw_word(k).getc(0) == c) begin
        kw_idx = k;
        kw_got = 1;
        keep_to(LX_KW);
        return 1'b1;
      end
    end
    case (c)
      CH_QUOTE: begin
        lx_state = LX_STR;
        return 1'b1;
      end
      CH_STAR:          nxt = LX_MUL;
      CH_SLASH:         nxt = LX_SLASH;
      CH_COLON:         nxt = LX_ASSIGN;
      CH_PLUS, CH_MINUS: nxt = LX_SUM;
      CH_BANG:          nxt = LX_NEG;
      CH_BAR:           nxt = LX_OR;
      CH_AMP:           nxt = LX_AND;
      CH_LPAREN:        nxt = LX_LPAR;
      CH_RPAREN:        nxt = LX_RPAR;
      CH_LT, CH_GT:     nxt = LX_REL;
      CH_EQ:            nxt = LX_REL_END;
      default: begin
        if (ch_letter(c)) nxt = LX_ID;
        else if (ch_digit(c)) nxt = LX_NUM;
        else return ch_blank(c);
      end
    endcase
    keep_to(nxt);
    return 1'b1;
  endfunction

  function automatic lex_result_t make_result(input logic [1:0] kind, input logic [4:0] tok,
                                              input logic [7:0] len);
    lex_result_t r;
    r.kind = kind;
    r.tok = tok;
    r.len = len;
    r.last = 1'b0;
    return r;
  endfunction

  // predict the results of one accepted character and queue them
  function automatic void lex_step(input logic [7:0] c, input logic eoi);
    lex_result_t out[2];
    int          n;
    lex_action_e act;
    logic [4:0]  tok;
    bit          done;
    n = 0;
    done = 1'b0;
    if (lx_state != LX_START) begin
      act = lex_pending(c, eoi, tok);
      if (act == LA_HELD) return;
      if (act == LA_TOKEN) begin
        out[n] = make_result(RK_TOKEN, tok, lx_kept);
        n++;
      end else if (act == LA_ERROR) begin
        // the offending character is dropped
        out[n] = make_result(RK_ERROR, TK_REL, 8'h00);
        n++;
        if (eoi) begin
          out[n] = make_result(RK_END, TK_REL, 8'h00);
          n++;
        end
        done = 1'b1;
      end
      lexer_clear();
    end
    if (!done) begin
      if (eoi) begin
        out[n] = make_result(RK_END, TK_REL, 8'h00);
        n++;
        lexer_clear();
      end else if (!lex_start(c)) begin
        out[n] = make_result(RK_ERROR, TK_REL, 8'h00);
        n++;
        lexer_clear();
      end
    end
    for (int i = 0; i < n; i++) begin
      out[i].last = (i == n - 1);
      results_due.push_back(out[i]);
    end
  endfunction

  // sender: offer the head of the pending queue, hold it until accepted
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        lex_step(s_tdata, s_tuser);
        void'(pending.pop_front());
        chars_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending[0].ch;
          s_tuser <= pending[0].eoi;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus long hold-off stretches on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    m_tready <= hold_left == 0 && hold_req == hold_seen && $urandom_range(99) >= recv_stall_pct;
  end

  always @(posedge clk) begin : result_check
    lex_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      case (m_tuser)
        RK_TOKEN: n_tokens++;
        RK_ERROR: n_errors++;
        default:  n_ends++;
      endcase
      if (results_due.size() == 0) begin
        $error("unexpected result: result_kind %0d token_kind %0d", m_tuser, m_tdata[4:0]);
        fails++;
      end else begin
        want = results_due.pop_front();
        if (m_tuser !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, m_tuser);
          fails++;
        end
        if (m_tdata[4:0] !== want.tok) begin
          $error("token_kind: expected %0d, got %0d", want.tok, m_tdata[4:0]);
          fails++;
        end
        if (m_tdata[12:5] !== want.len) begin
          $error("lexeme_length: expected %0d, got %0d", want.len, m_tdata[12:5]);
          fails++;
        end
        if (m_tlast !== want.last) begin
          $error("last_result: expected %0d, got %0d", want.last, m_tlast);
          fails++;
        end
      end
    end
  end

  task automatic put_byte(input logic [7:0] c);
    lex_char_t it;
    it.ch = c;
    it.eoi = 1'b0;
    pending.push_back(it);
  endtask

  task automatic put_eoi();
    lex_char_t it;
    it.ch = 8'($urandom_range(255));
    it.eoi = 1'b1;
    pending.push_back(it);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s.getc(i));
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1) == 0 ? 8'h61 : 8'h41) + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_word_char();
    case ($urandom_range(2))
      0:       return rand_letter();
      1:       return 8'h30 + 8'($urandom_range(9));
      default: return CH_UNDER;
    endcase
  endfunction

  // string and comment body: mostly printable, sometimes newline, star or any byte
  function automatic logic [7:0] rand_text_char();
    logic [7:0] c;
    case ($urandom_range(9))
      0:       c = CH_NL;
      1:       c = 8'($urandom_range(255));
      2:       c = CH_STAR;
      default: c = 8'($urandom_range(32, 126));
    endcase
    return c == CH_QUOTE ? CH_UNDER : c;
  endfunction

  task automatic put_fragment();
    string w;
    int    n;
    case ($urandom_range(19))
      0: put_text(kw_word($urandom_range(NUM_KW - 1)));
      1: begin
        w = kw_word($urandom_range(NUM_KW - 1));
        put_text(w.substr(0, $urandom_range(w.len() - 2)));
      end
      2: begin
        put_text(kw_word($urandom_range(NUM_KW - 1)));
        repeat ($urandom_range(1, 3)) put_byte(rand_word_char());
      end
      3: begin
        put_byte(rand_letter());
        repeat ($urandom_range(7)) put_byte(rand_word_char());
      end
      4: repeat ($urandom_range(1, 6)) put_byte(8'h30 + 8'($urandom_range(9)));
      5: begin
        put_byte(CH_QUOTE);
        repeat ($urandom_range(8)) put_byte(rand_text_char());
        if ($urandom_range(7) != 0) put_byte(CH_QUOTE);
      end
      6: begin
        put_text("//");
        repeat ($urandom_range(6)) put_byte(rand_text_char());
        put_byte(CH_NL);
      end
      7: begin
        put_text("/*");
        repeat ($urandom_range(6)) put_byte(rand_text_char());
        repeat ($urandom_range(1, 3)) put_byte(CH_STAR);
        put_byte(CH_SLASH);
      end
      8: begin
        case ($urandom_range(5))
          0:       put_text("<");
          1:       put_text(">");
          2:       put_text("<=");
          3:       put_text(">=");
          4:       put_text("=");
          default: put_text("!=");
        endcase
      end
      9: begin
        case ($urandom_range(2))
          0:       put_text(":=");
          1:       put_text("||");
          default: put_text("&&");
        endcase
      end
      10: begin
        w = "+-*/!";
        put_byte(w.getc($urandom_range(4)));
      end
      11: put_byte($urandom_range(1) == 0 ? CH_LPAREN : CH_RPAREN);
      12: begin
        // a two-character operator with a random second character
        w = ":|&";
        put_byte(w.getc($urandom_range(2)));
        put_byte(8'($urandom_range(255)));
      end
      13: put_byte(8'($urandom_range(255)));
      14: put_eoi();
      default: begin
        n = $urandom_range(5);
        put_byte(n == 5 ? CH_SPACE : 8'(9 + n));
      end
    endcase
  endtask

  // wait until every pending character is sent and every expected result has come
  task automatic settle();
    while (pending.size() != 0 || results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input int sidle, input int rstall, input bit hold);
    int target;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    if (hold) hold_req++;
    target = pending.size() + 30;
    while (pending.size() < target) put_fragment();
    put_eoi();
    settle();
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // bad characters at both ends of the byte range, broken assign
    put_byte(8'h00);
    put_byte(8'hFF);
    put_text(":x");
    // newline inside a string, block comment closed by a run of stars
    put_byte(CH_QUOTE);
    put_text("a");
    put_byte(CH_NL);
    put_text("b");
    put_byte(CH_QUOTE);
    put_text("/***/");
    // what is pending when the text ends
    put_byte(CH_QUOTE);
    put_text("ab");
    put_eoi();
    put_text("/*");
    put_eoi();
    put_text("//");
    put_eoi();
    put_text("&");
    put_eoi();
    put_text("x");
    put_eoi();
    settle();

    // long receiver hold-off while the sender keeps offering text
    run_phase(0, 0, 1'b1);
    // overlong identifier saturates the length
    put_byte(rand_letter());
    repeat (259) put_byte(rand_word_char());
    put_byte(CH_SPACE);
    run_phase(59, 0, 1'b0);
    run_phase(0, 59, 1'b0);
    run_phase(26, 26, 1'b1);

    repeat (20) @(posedge clk);
    $display("Lexed %0d characters: edge cases, overlong tokens, random text under idle,",
             chars_in);
    $display("stall and hold-off phases; %0d tokens, %0d errors, %0d end marks checked",
             n_tokens, n_errors, n_ends);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
